[rtl/core/pro_pkg.sv]
// shared types and constants of the polyline ribbon outline block
`default_nettype none
package pro_pkg;

  localparam int CNT_W       = 5;
  localparam int SQRT_STEPS  = 31;
  localparam int CROSS_STEPS = 6;

  localparam logic TGT_EDGE   = 1'b0;
  localparam logic TGT_BINORM = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD_EDGE,
    OP_SHIFT,
    OP_SQ,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_ZERO,
    OP_CROSS,
    OP_LOAD_CROSS,
    OP_EMIT,
    OP_COMMIT
  } op_t;

  typedef enum logic [1:0] {
    SEL_PBP,
    SEL_PREV,
    SEL_CUR,
    SEL_SHORT
  } sel_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
    logic             tgt;
    sel_t             sel;
  } cmd_t;

  typedef struct packed {
    logic       vec_zero;
    logic       in_range;
    logic       big;
    logic [1:0] phase;
    logic       last;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/polyline_ribbon_outline.sv]
// top level of the polyline ribbon outline block
//
// points of a 3d polyline enter on the in_ stream one transaction at a time,
// in_tlast marking the final point of a line. for every vertex the block sends
// a north and south outline vertex (point plus and minus the unit binormal)
// on the out_ stream; out_tlast marks the final result of the line.
// results for vertex i leave once point i+1 has arrived: the third point
// releases vertices 0 and 1, the last point also releases its own vertex.
// a line of fewer than three points gives one result with too_short set.
// each point after the first runs through one or two normalisations (edge and
// binormal) on a shared iterative unit: a one-bit-per-cycle range shift, three
// squares, a 31-step square root and three 18-step divides (FRAC_BITS + 2 steps);
// the time a typical inner point takes is set by the square root and divide loops.
// in_tready is high only between points; the next point may be taken while
// a finished result still waits in the output register.
// a stalled receiver holds the output register and the sequencer waits.
// synchronous active-low reset empties the line history and the output.
`default_nettype none
module polyline_ribbon_outline #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,  // point_x, point_y, point_z
  input  wire              in_tlast,                  // last_point
  output logic             out_tvalid,
  input  wire              out_tready,
  // north_x, north_y, north_z, south_x, south_y, south_z, vertex_index
  output logic [((6*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] out_tdata,
  output logic             out_tlast,                 // last_vertex
  output logic [1:0]       out_tuser                  // degenerate, too_short
);
  import pro_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((6 * COORD_BITS + INDEX_BITS + 7) / 8) * 8;

  cmd_t  cmd;
  stat_t stat;

  logic [C-1:0]          nx, ny, nz, sx, sy, sz;
  logic [INDEX_BITS-1:0] vidx;
  logic                  deg;
  logic                  shrt;

  // sequencer
  pro_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // history, normaliser and output register
  pro_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_x      (in_tdata[C-1:0]),
    .point_y      (in_tdata[2*C-1:C]),
    .point_z      (in_tdata[3*C-1:2*C]),
    .last_point   (in_tlast),
    .cmd          (cmd),
    .stat         (stat),
    .north_x      (nx),
    .north_y      (ny),
    .north_z      (nz),
    .south_x      (sx),
    .south_y      (sy),
    .south_z      (sz),
    .vertex_index (vidx),
    .last_vertex  (out_tlast),
    .degenerate   (deg),
    .too_short    (shrt)
  );

  // fields packed from the lowest bit up, zero filled to whole bytes
  assign out_tdata = OUT_W'({vidx, sz, sy, sx, nz, ny, nx});
  assign out_tuser = {shrt, deg};

endmodule
`default_nettype wire

[rtl/core/pro_ctrl.sv]
// sequencer for normalisation, cross product and result emission
`default_nettype none
module pro_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire            out_tready,
  input  pro_pkg::stat_t stat,
  output pro_pkg::cmd_t  cmd
);
  import pro_pkg::*;

  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] CROSS_LAST = CNT_W'(CROSS_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD_EDGE, S_SHIFT, S_SQ, S_SQRT, S_DIV_INIT, S_DIV_STEP,
    S_DIV_STORE, S_CROSS, S_LOAD_CROSS, S_PICK, S_EMIT, S_COMMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0]       comp_r;
  logic             tgt_r;
  sel_t             sel_r;
  logic             out_valid_r;
  logic             emit_ok;
  logic             want_cross;

  assign emit_ok    = !out_valid_r || out_tready;
  assign want_cross = (tgt_r == TGT_EDGE) && stat.phase[1];
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.cnt  = cnt_r;
    cmd.comp = comp_r;
    cmd.tgt  = tgt_r;
    cmd.sel  = sel_r;
    case (state_r)
      S_IDLE:       cmd.op = in_tvalid ? OP_ACCEPT : OP_NONE;
      S_LOAD_EDGE:  cmd.op = OP_LOAD_EDGE;
      S_SHIFT:      cmd.op = stat.vec_zero ? OP_ZERO : (stat.in_range ? OP_NONE : OP_SHIFT);
      S_SQ:         cmd.op = OP_SQ;
      S_SQRT:       cmd.op = OP_SQRT;
      S_DIV_INIT:   cmd.op = OP_DIV_INIT;
      S_DIV_STEP:   cmd.op = OP_DIV_STEP;
      S_DIV_STORE:  cmd.op = OP_DIV_STORE;
      S_CROSS:      cmd.op = OP_CROSS;
      S_LOAD_CROSS: cmd.op = OP_LOAD_CROSS;
      S_EMIT:       cmd.op = emit_ok ? OP_EMIT : OP_NONE;
      S_COMMIT:     cmd.op = OP_COMMIT;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      tgt_r       <= TGT_EDGE;
      sel_r       <= SEL_SHORT;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            tgt_r   <= TGT_EDGE;
            state_r <= (stat.phase == 2'd0) ? S_PICK : S_LOAD_EDGE;
          end
        end
        S_LOAD_EDGE: state_r <= S_SHIFT;
        S_SHIFT: begin
          if (stat.vec_zero) begin
            cnt_r   <= '0;
            state_r <= want_cross ? S_CROSS : S_PICK;
          end else if (stat.in_range) begin
            comp_r  <= 2'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (comp_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            comp_r <= comp_r + 2'd1;
          end
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SQRT_LAST) begin
            comp_r  <= 2'd0;
            state_r <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          cnt_r   <= '0;
          state_r <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) state_r <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (comp_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= want_cross ? S_CROSS : S_PICK;
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_DIV_INIT;
          end
        end
        S_CROSS: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CROSS_LAST) state_r <= S_LOAD_CROSS;
        end
        S_LOAD_CROSS: begin
          tgt_r   <= TGT_BINORM;
          state_r <= S_SHIFT;
        end
        S_PICK: begin
          if (stat.phase[1]) begin
            sel_r   <= (stat.phase == 2'd2) ? SEL_PBP : SEL_PREV;
            state_r <= S_EMIT;
          end else if (stat.last) begin
            sel_r   <= SEL_SHORT;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            case (sel_r)
              SEL_PBP:  sel_r <= SEL_PREV;
              SEL_PREV: begin
                if (stat.last) sel_r <= SEL_CUR;
                else state_r <= S_COMMIT;
              end
              default:  state_r <= S_COMMIT;
            endcase
          end
        end
        S_COMMIT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/pro_dp.sv]
// datapath: point history, iterative normaliser, cross product and outline result register
`default_nettype none
module pro_dp #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire signed [COORD_BITS-1:0] point_x,
  input  wire signed [COORD_BITS-1:0] point_y,
  input  wire signed [COORD_BITS-1:0] point_z,
  input  wire                         last_point,
  input  pro_pkg::cmd_t               cmd,
  output pro_pkg::stat_t              stat,
  output logic [COORD_BITS-1:0]       north_x,
  output logic [COORD_BITS-1:0]       north_y,
  output logic [COORD_BITS-1:0]       north_z,
  output logic [COORD_BITS-1:0]       south_x,
  output logic [COORD_BITS-1:0]       south_y,
  output logic [COORD_BITS-1:0]       south_z,
  output logic [INDEX_BITS-1:0]       vertex_index,
  output logic                        last_vertex,
  output logic                        degenerate,
  output logic                        too_short
);
  import pro_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = (C + 1 > 2 * F + 2) ? C + 1 : 2 * F + 2;
  localparam int MW = (NW > 30) ? NW : 30;
  localparam int XW = 2 * F + 5;
  localparam int UW = F + 2;
  localparam int Q  = UW;
  localparam int DW = 31 + F;
  localparam int AW = (MW > XW) ? MW : XW;
  localparam int OW = ((C > UW) ? C : UW) + 1;
  localparam logic signed [OW-1:0] SAT_HI = OW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

  logic signed [C-1:0]  cur_r  [3];
  logic signed [C-1:0]  prev_r [3];
  logic signed [C-1:0]  pbp_r  [3];
  logic signed [UW-1:0] a_r    [3];
  logic signed [UW-1:0] e_r    [3];
  logic signed [UW-1:0] bn_r   [3];
  logic signed [XW-1:0] cr_r   [3];
  logic [MW-1:0]        m_r    [3];
  logic                 neg_r  [3];
  logic                 last_r;
  logic                 deg_r;
  logic [1:0]           phase_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [61:0]          acc_r;
  logic [31:0]          rem_r;
  logic [30:0]          root_r;
  logic [31:0]          drem_r;
  logic [Q-1:0]         dlow_r;
  logic [Q-1:0]         q_r;

  // normaliser operands
  logic signed [AW-1:0] ed   [3];
  logic signed [AW-1:0] cx   [3];
  logic [AW-1:0]        ed_a [3];
  logic [AW-1:0]        cx_a [3];
  logic [59:0]          sq_prod;
  logic [33:0]          sq_t;
  logic [33:0]          sq_trial;
  logic [DW-1:0]        dvd;
  logic [32:0]          dv_t;
  logic [32:0]          dv_l;
  logic signed [UW-1:0] q_s;
  logic signed [UW-1:0] mul_a;
  logic signed [UW-1:0] mul_b;
  logic signed [2*UW-1:0] mul_p;
  logic signed [XW-1:0] mul_x;
  logic                 any_big;
  logic                 any_hi;

  // result formation
  logic signed [C-1:0]  pt [3];
  logic signed [UW-1:0] bo [3];
  logic signed [OW-1:0] sum_n [3];
  logic signed [OW-1:0] sum_s [3];
  logic [C-1:0]         nv [3];
  logic [C-1:0]         sv [3];
  logic [INDEX_BITS-1:0] e_idx;

  function automatic logic [C-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[C-1:0];
  endfunction

  always_comb begin
    any_big = 1'b0;
    any_hi  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ed[k]   = AW'(cur_r[k]) - AW'(prev_r[k]);
      ed_a[k] = ed[k][AW-1] ? AW'(-ed[k]) : AW'(ed[k]);
      cx[k]   = AW'(cr_r[k]);
      cx_a[k] = cx[k][AW-1] ? AW'(-cx[k]) : AW'(cx[k]);
      if ((m_r[k] >> 30) != '0) any_big = 1'b1;
      if ((m_r[k] >> 29) != '0) any_hi = 1'b1;
    end
    stat.vec_zero = (m_r[0] == '0) && (m_r[1] == '0) && (m_r[2] == '0);
    stat.big      = any_big;
    stat.in_range = any_hi && !any_big;
    stat.phase    = phase_r;
    stat.last     = last_r;
  end

  assign sq_prod  = m_r[cmd.comp][29:0] * m_r[cmd.comp][29:0];
  assign sq_t     = {rem_r, acc_r[61:60]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dvd      = {1'b0, m_r[cmd.comp][29:0], {F{1'b0}}} + DW'(root_r >> 1);
  assign dv_t     = {drem_r, dlow_r[Q-1]};
  assign dv_l     = {2'b00, root_r};
  assign q_s      = neg_r[cmd.comp] ? -$signed(q_r) : $signed(q_r);

  // cross product operands, one product per step
  always_comb begin
    case (cmd.cnt[2:0])
      3'd0:    begin mul_a = a_r[1]; mul_b = e_r[2]; end
      3'd1:    begin mul_a = a_r[2]; mul_b = e_r[1]; end
      3'd2:    begin mul_a = a_r[2]; mul_b = e_r[0]; end
      3'd3:    begin mul_a = a_r[0]; mul_b = e_r[2]; end
      3'd4:    begin mul_a = a_r[0]; mul_b = e_r[1]; end
      default: begin mul_a = a_r[1]; mul_b = e_r[0]; end
    endcase
    mul_p = mul_a * mul_b;
    mul_x = XW'(mul_p);
  end

  always_comb begin
    e_idx = idx_r;
    for (int k = 0; k < 3; k++) begin
      pt[k] = cur_r[k];
      bo[k] = bn_r[k];
    end
    case (cmd.sel)
      SEL_PBP: begin
        for (int k = 0; k < 3; k++) pt[k] = pbp_r[k];
        e_idx = idx_r - INDEX_BITS'(2);
      end
      SEL_PREV: begin
        for (int k = 0; k < 3; k++) pt[k] = prev_r[k];
        e_idx = idx_r - INDEX_BITS'(1);
      end
      SEL_CUR: e_idx = idx_r;
      default: begin
        for (int k = 0; k < 3; k++) begin
          pt[k] = '0;
          bo[k] = '0;
        end
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      sum_n[k] = OW'(pt[k]) + OW'(bo[k]);
      sum_s[k] = OW'(pt[k]) - OW'(bo[k]);
      nv[k]    = sat(sum_n[k]);
      sv[k]    = sat(sum_s[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      idx_r   <= '0;
      last_r  <= 1'b0;
      deg_r   <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          cur_r[0] <= point_x;
          cur_r[1] <= point_y;
          cur_r[2] <= point_z;
          last_r   <= last_point;
          for (int k = 0; k < 3; k++) e_r[k] <= '0;
        end
        OP_LOAD_EDGE: begin
          for (int k = 0; k < 3; k++) begin
            m_r[k]   <= ed_a[k][MW-1:0];
            neg_r[k] <= ed[k][AW-1];
          end
        end
        OP_LOAD_CROSS: begin
          deg_r <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            m_r[k]   <= cx_a[k][MW-1:0];
            neg_r[k] <= cx[k][AW-1];
          end
        end
        OP_SHIFT: begin
          for (int k = 0; k < 3; k++) m_r[k] <= any_big ? (m_r[k] >> 1) : (m_r[k] << 1);
        end
        OP_ZERO: begin
          for (int k = 0; k < 3; k++) begin
            if (cmd.tgt == TGT_BINORM) bn_r[k] <= '0;
            else e_r[k] <= '0;
          end
          if (cmd.tgt == TGT_BINORM) deg_r <= 1'b1;
        end
        OP_SQ: begin
          if (cmd.comp == 2'd0) begin
            acc_r  <= 62'(sq_prod);
            rem_r  <= '0;
            root_r <= '0;
          end else begin
            acc_r <= acc_r + 62'(sq_prod);
          end
        end
        OP_SQRT: begin
          acc_r <= acc_r << 2;
          if (sq_t >= sq_trial) begin
            rem_r  <= 32'(sq_t - sq_trial);
            root_r <= {root_r[29:0], 1'b1};
          end else begin
            rem_r  <= sq_t[31:0];
            root_r <= {root_r[29:0], 1'b0};
          end
        end
        OP_DIV_INIT: begin
          drem_r <= 32'(dvd[DW-1:Q]);
          dlow_r <= dvd[Q-1:0];
          q_r    <= '0;
        end
        OP_DIV_STEP: begin
          dlow_r <= dlow_r << 1;
          if (dv_t >= dv_l) begin
            drem_r <= 32'(dv_t - dv_l);
            q_r    <= {q_r[Q-2:0], 1'b1};
          end else begin
            drem_r <= dv_t[31:0];
            q_r    <= {q_r[Q-2:0], 1'b0};
          end
        end
        OP_DIV_STORE: begin
          if (cmd.tgt == TGT_BINORM) bn_r[cmd.comp] <= q_s;
          else e_r[cmd.comp] <= q_s;
        end
        OP_CROSS: begin
          case (cmd.cnt[2:0])
            3'd0:    cr_r[0] <= mul_x;
            3'd1:    cr_r[0] <= cr_r[0] - mul_x;
            3'd2:    cr_r[1] <= mul_x;
            3'd3:    cr_r[1] <= cr_r[1] - mul_x;
            3'd4:    cr_r[2] <= mul_x;
            default: cr_r[2] <= cr_r[2] - mul_x;
          endcase
        end
        OP_EMIT: begin
          north_x      <= nv[0];
          north_y      <= nv[1];
          north_z      <= nv[2];
          south_x      <= sv[0];
          south_y      <= sv[1];
          south_z      <= sv[2];
          vertex_index <= e_idx;
          last_vertex  <= (cmd.sel == SEL_CUR) || (cmd.sel == SEL_SHORT);
          degenerate   <= (cmd.sel != SEL_SHORT) && deg_r;
          too_short    <= (cmd.sel == SEL_SHORT);
        end
        OP_COMMIT: begin
          if (last_r) begin
            phase_r <= 2'd0;
            idx_r   <= '0;
          end else begin
            for (int k = 0; k < 3; k++) begin
              pbp_r[k]  <= prev_r[k];
              prev_r[k] <= cur_r[k];
              a_r[k]    <= e_r[k];
            end
            idx_r <= idx_r + INDEX_BITS'(1);
            if (phase_r != 2'd3) phase_r <= phase_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/pro_checker.sv]
// port-level checks of the polyline ribbon outline block and their binding
`default_nettype none
module pro_checker #(
  parameter int OUT_W = 208
) (
  input wire             clk,
  input wire             rst_n,
  input wire             in_tvalid,
  input wire             in_tready,
  input wire             out_tvalid,
  input wire             out_tready,
  input wire [OUT_W-1:0] out_tdata,
  input wire             out_tlast,
  input wire [1:0]       out_tuser
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a too-short line closes at once and is never degenerate
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("too-short result malformed");

  // each accepted point drops in_tready, so points are never taken back to back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("point taken back to back");

endmodule

bind polyline_ribbon_outline pro_checker #(
  .OUT_W (OUT_W)
) u_pro_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
